[sv/ecs_pkg.sv]
// elevator call scheduler: shared sizes, direction and kind codes,
// and the command types between controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ecs_pkg;

    localparam int FLOORS  = 16;
    localparam int FLOOR_W = 6;
    localparam int IDX_W   = (FLOORS > 1) ? $clog2(FLOORS) : 1;

    typedef logic [FLOOR_W-1:0] floor_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic signed [1:0]  dir_t;
    typedef logic [1:0]         kind_t;

    localparam dir_t DIR_STOP = 2'sb00;
    localparam dir_t DIR_UP   = 2'sb01;
    localparam dir_t DIR_DOWN = 2'sb11;

    localparam kind_t KIND_HALL = 2'd0;
    localparam kind_t KIND_CAR  = 2'd1;
    localparam kind_t KIND_TICK = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_EXEC,
        OP_DOOR,
        OP_RETARGET,
        OP_MOVE
    } dp_op_t;

    typedef struct packed {
        logic   load_item;
        dp_op_t op;
        logic   load_out;
    } ecs_cmd_t;

endpackage

`default_nettype wire

[sv/ecs_datapath.sv]
// elevator call scheduler datapath: request stores, car state,
// request scan and the result register; uses ecs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ecs_datapath
    import ecs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire kind_t    kind,
    input  wire floor_t   floor,
    input  wire dir_t     call_dir,
    input  wire ecs_cmd_t cmd,
    output floor_t        current_floor,
    output floor_t        target_floor,
    output dir_t          moving_dir,
    output logic          door_open,
    output logic          illegal
);

    // request held for the running item
    kind_t  kind_reg;
    floor_t floor_reg;
    dir_t   dir_reg;

    logic [FLOORS-1:0][1:0] hall_reg, hall_next;
    logic [FLOORS-1:0]      car_reg, car_next;
    floor_t car_floor_reg, car_floor_next;
    floor_t goal_reg, goal_next;
    dir_t   travel_reg, travel_next;
    logic   door_reg, door_next;
    logic   bad_reg, bad_next;

    floor_t out_cur_reg, out_goal_reg;
    dir_t   out_dir_reg;
    logic   out_door_reg, out_bad_reg;

    logic [FLOORS-1:0] req;
    idx_t   lo_idx, hi_idx;
    logic   any_req;
    idx_t   req_idx, car_idx;
    logic   floor_ok, dir_ok;
    floor_t scan_f;
    dir_t   td;
    floor_t g;

    // priority encode of pending floors
    always_comb
    begin
        lo_idx = '0;
        hi_idx = '0;
        for (int i = 0; i < FLOORS; i++)
        begin
            req[i] = (hall_reg[i] != 2'b00) || car_reg[i];
        end
        for (int i = FLOORS - 1; i >= 0; i--)
        begin
            if (req[i])
            begin
                lo_idx = idx_t'(i);
            end
        end
        for (int i = 0; i < FLOORS; i++)
        begin
            if (req[i])
            begin
                hi_idx = idx_t'(i);
            end
        end
        any_req = |req;
    end

    assign req_idx  = floor_reg[IDX_W-1:0];
    assign car_idx  = car_floor_reg[IDX_W-1:0];
    assign floor_ok = ({1'b0, floor_reg} < (FLOOR_W + 1)'(FLOORS));
    assign dir_ok   = (dir_reg == DIR_UP) || (dir_reg == DIR_DOWN);

    always_comb
    begin
        hall_next      = hall_reg;
        car_next       = car_reg;
        car_floor_next = car_floor_reg;
        goal_next      = goal_reg;
        travel_next    = travel_reg;
        door_next      = door_reg;
        bad_next       = bad_reg;
        td             = travel_reg;
        g              = goal_reg;
        scan_f         = '0;

        case (cmd.op)
            OP_EXEC:
            begin
                case (kind_reg)
                    KIND_HALL:
                    begin
                        if (floor_ok && dir_ok)
                        begin
                            if (travel_reg == DIR_STOP)
                            begin
                                td = (floor_reg > car_floor_reg) ? DIR_UP : DIR_DOWN;
                                g  = floor_reg;
                            end
                            if ((floor_reg > g && td == DIR_UP) ||
                                (floor_reg < g && td == DIR_DOWN))
                            begin
                                g = floor_reg;
                            end
                            travel_next        = td;
                            goal_next          = g;
                            hall_next[req_idx] = dir_reg;
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    KIND_CAR:
                    begin
                        if (floor_ok)
                        begin
                            car_next[req_idx] = ~car_reg[req_idx];
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        bad_next = 1'b1;
                    end
                endcase
            end
            OP_DOOR:
            begin
                if (hall_reg[car_idx] != 2'b00 && dir_t'(hall_reg[car_idx]) == travel_reg)
                begin
                    door_next          = 1'b1;
                    hall_next[car_idx] = 2'b00;
                end
                if (car_reg[car_idx])
                begin
                    door_next         = 1'b1;
                    car_next[car_idx] = 1'b0;
                end
                if (car_floor_reg == goal_reg && travel_reg != DIR_STOP)
                begin
                    door_next          = 1'b1;
                    travel_next        = DIR_STOP;
                    hall_next[car_idx] = 2'b00;
                end
            end
            OP_RETARGET:
            begin
                // stopped car starts toward the lowest request
                if (travel_reg == DIR_STOP && any_req)
                begin
                    if (car_floor_reg < floor_t'(lo_idx))
                    begin
                        td = DIR_UP;
                        g  = floor_t'(lo_idx);
                    end
                    else if (car_floor_reg > floor_t'(lo_idx))
                    begin
                        td = DIR_DOWN;
                        g  = floor_t'(lo_idx);
                    end
                end
                scan_f = (td == DIR_DOWN) ? floor_t'(lo_idx) : floor_t'(hi_idx);
                if (any_req && scan_f != car_floor_reg)
                begin
                    g = scan_f;
                end
                travel_next = td;
                goal_next   = g;
            end
            OP_MOVE:
            begin
                if (travel_reg == DIR_UP)
                begin
                    if (car_floor_reg == floor_t'(FLOORS - 1))
                    begin
                        travel_next = DIR_STOP;
                    end
                    else
                    begin
                        car_floor_next = car_floor_reg + floor_t'(1);
                    end
                end
                else if (travel_reg == DIR_DOWN)
                begin
                    if (car_floor_reg == '0)
                    begin
                        travel_next = DIR_STOP;
                    end
                    else
                    begin
                        car_floor_next = car_floor_reg - floor_t'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (cmd.load_item)
        begin
            door_next = 1'b0;
            bad_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hall_reg      <= '0;
            car_reg       <= '0;
            car_floor_reg <= '0;
            goal_reg      <= '0;
            travel_reg    <= DIR_STOP;
            door_reg      <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            hall_reg      <= hall_next;
            car_reg       <= car_next;
            car_floor_reg <= car_floor_next;
            goal_reg      <= goal_next;
            travel_reg    <= travel_next;
            door_reg      <= door_next;
            bad_reg       <= bad_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg  <= kind;
            floor_reg <= floor;
            dir_reg   <= call_dir;
        end
        if (cmd.load_out)
        begin
            out_cur_reg  <= car_floor_reg;
            out_goal_reg <= goal_reg;
            out_dir_reg  <= travel_reg;
            out_door_reg <= door_reg;
            out_bad_reg  <= bad_reg;
        end
    end

    assign current_floor = out_cur_reg;
    assign target_floor  = out_goal_reg;
    assign moving_dir    = out_dir_reg;
    assign door_open     = out_door_reg;
    assign illegal       = out_bad_reg;

endmodule

`default_nettype wire

[sv/ecs_controller.sv]
// elevator call scheduler sequencer: input/output handshake and
// the step order for calls and ticks; uses ecs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ecs_controller
    import ecs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire kind_t kind,
    output logic       out_valid,
    input  wire logic  out_stall,
    output ecs_cmd_t   cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_EXEC     = 6'b000010,
        S_DOOR     = 6'b000100,
        S_RETARGET = 6'b001000,
        S_MOVE     = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;
        cmd            = '{load_item: 1'b0, op: OP_NONE, load_out: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = (kind == KIND_TICK) ? S_DOOR : S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.op     = OP_EXEC;
                state_next = S_DONE;
            end
            S_DOOR:
            begin
                cmd.op     = OP_DOOR;
                state_next = S_RETARGET;
            end
            S_RETARGET:
            begin
                cmd.op     = OP_RETARGET;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.op     = OP_MOVE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/elevator_call_scheduler_core.sv]
// result: a hall call or car button request runs the exec step, a tick the door
// check, retarget and move steps (separate steps), then the done step raises out_valid
// one request at a time: no new request is taken until the sequencer is back in
// idle; a waiting result holds the next request in its last step
// reset: asynchronous, clears all calls, car at floor 0, target 0, stopped
// top level; uses ecs_pkg, ecs_controller and ecs_datapath
`timescale 1ns / 1ps
`default_nettype none

module elevator_call_scheduler_core
    import ecs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    // request channel
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire kind_t  kind,
    input  wire floor_t floor,
    input  wire dir_t   call_dir,
    // result channel
    output logic        out_valid,
    input  wire logic   out_stall,
    output floor_t      current_floor,
    output floor_t      target_floor,
    output dir_t        moving_dir,
    output logic        door_open,
    output logic        illegal
);

    // sequencer commands toward the datapath
    ecs_cmd_t cmd;

    // sequencer: one request at a time, steps through the work for its kind
    ecs_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath: hall and car request stores, car position, target, direction
    // and the result register that holds a finished result until taken
    ecs_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (kind),
        .floor         (floor),
        .call_dir      (call_dir),
        .cmd           (cmd),
        .current_floor (current_floor),
        .target_floor  (target_floor),
        .moving_dir    (moving_dir),
        .door_open     (door_open),
        .illegal       (illegal)
    );

    // car never reported outside the shaft
    a_floor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, current_floor} < (FLOOR_W + 1)'(FLOORS)))
        else $error("car floor out of range");

    // a door opening only comes from a tick, a rejection never does
    a_door_vs_illegal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(door_open && illegal))
        else $error("door open and illegal together");

    // an accepted request blocks the input until its result is built
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again while busy");

    // direction code stays one of up, down, stopped
    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (moving_dir != 2'sb10))
        else $error("bad direction code");

endmodule

`default_nettype wire

[test/tb.sv]
// testbench for elevator_call_scheduler_core: directed table then random requests,
// every result checked against a cycle-free predictor of the car and its calls
// depends on ecs_pkg and the core rtl
`timescale 1ns / 1ps

module tb;
    import ecs_pkg::*;

    // kind and direction codes the package leaves out, used to provoke rejects
    localparam kind_t KIND_UNUSED = 2'd3;
    localparam dir_t  DIR_BAD     = 2'sb10;

    localparam int RANDOM_REQUESTS = 1925;
    localparam int QUIET_TAIL      = 200;     // last requests run with no idling
    localparam int DRAIN_CYCLES    = 12;      // idle margin after the last awaited result
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PRINT_LIMIT     = 40;

    typedef struct packed {
        floor_t cur;
        floor_t tgt;
        dir_t   dir;
        logic   door;
        logic   bad;
    } car_report_t;

    typedef struct packed {
        kind_t       kind;
        floor_t      flr;
        dir_t        dir;
        logic        typed;   // 1: want below is the expected result as written
        car_report_t want;
    } stim_row_t;

    // results that are plain to see while the car still sits at floor 0
    localparam car_report_t REJECT_AT_HOME = '{cur: '0, tgt: '0, dir: DIR_STOP,
                                               door: 1'b0, bad: 1'b1};
    localparam car_report_t IDLE_AT_HOME   = '{cur: '0, tgt: '0, dir: DIR_STOP,
                                               door: 1'b0, bad: 1'b0};
    localparam car_report_t NO_WANT        = '0;

    localparam int DIRECTED_ROWS = 25;

    // directed requests: rejects at reset, then a short trip that exercises a
    // call at the car's own floor, a call past the target, arrival and cancels
    stim_row_t directed [DIRECTED_ROWS] = '{
        '{KIND_UNUSED, 6'd0,  DIR_STOP, 1'b1, REJECT_AT_HOME},  // unused kind
        '{KIND_HALL,   6'd16, DIR_UP,   1'b1, REJECT_AT_HOME},  // first floor too high
        '{KIND_HALL,   6'd63, DIR_DOWN, 1'b1, REJECT_AT_HOME},  // top of floor field
        '{KIND_HALL,   6'd5,  DIR_STOP, 1'b1, REJECT_AT_HOME},  // no direction
        '{KIND_HALL,   6'd42, DIR_BAD,  1'b1, REJECT_AT_HOME},  // direction code 2
        '{KIND_CAR,    6'd16, DIR_STOP, 1'b1, REJECT_AT_HOME},
        '{KIND_CAR,    6'd63, DIR_UP,   1'b1, REJECT_AT_HOME},
        '{KIND_TICK,   6'd0,  DIR_STOP, 1'b1, IDLE_AT_HOME},    // nothing to serve
        '{KIND_HALL,   6'd0,  DIR_UP,   1'b0, NO_WANT},         // own floor, starts down
        '{KIND_TICK,   6'd21, DIR_BAD,  1'b0, NO_WANT},         // arrives at once
        '{KIND_CAR,    6'd15, DIR_STOP, 1'b0, NO_WANT},
        '{KIND_HALL,   6'd3,  DIR_DOWN, 1'b0, NO_WANT},
        '{KIND_HALL,   6'd10, DIR_UP,   1'b0, NO_WANT},         // beyond the target
        '{KIND_TICK,   6'd0,  DIR_STOP, 1'b0, NO_WANT},
        '{KIND_TICK,   6'd0,  DIR_STOP, 1'b0, NO_WANT},
        '{KIND_TICK,   6'd0,  DIR_STOP, 1'b0, NO_WANT},
        '{KIND_TICK,   6'd0,  DIR_STOP, 1'b0, NO_WANT},
        '{KIND_TICK,   6'd0,  DIR_STOP, 1'b0, NO_WANT},
        '{KIND_CAR,    6'd15, DIR_STOP, 1'b0, NO_WANT},         // cancel the top call
        '{KIND_HALL,   6'd1,  DIR_DOWN, 1'b0, NO_WANT},
        '{KIND_TICK,   6'd0,  DIR_STOP, 1'b0, NO_WANT},
        '{KIND_TICK,   6'd0,  DIR_STOP, 1'b0, NO_WANT},
        '{KIND_TICK,   6'd0,  DIR_STOP, 1'b0, NO_WANT},
        '{KIND_TICK,   6'd0,  DIR_STOP, 1'b0, NO_WANT},
        '{KIND_UNUSED, 6'd63, DIR_BAD,  1'b0, NO_WANT}          // reject mid trip
    };

    logic   clk;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   in_stall;
    kind_t  req_kind  = KIND_TICK;
    floor_t req_floor = '0;
    dir_t   req_dir   = DIR_STOP;
    logic   out_valid;
    logic   out_stall = 1'b0;
    floor_t current_floor;
    floor_t target_floor;
    dir_t   moving_dir;
    logic   door_open;
    logic   illegal;

    // written expectation that travels with the request on the bus
    logic        row_typed = 1'b0;
    car_report_t row_want  = '0;

    bit quiet_tail = 1'b0;
    int stall_pct  = 30;
    int mismatches = 0;
    int results_seen = 0;

    car_report_t awaited_reports [$];

    // predicted car: stored hall directions, car buttons, position, goal, heading
    dir_t hall_dir [FLOORS] = '{default: DIR_STOP};
    bit   cab_req  [FLOORS] = '{default: 1'b0};
    int   car_pos  = 0;
    int   goal_pos = 0;
    int   heading  = 0;

    elevator_call_scheduler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (req_kind),
        .floor         (req_floor),
        .call_dir      (req_dir),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .current_floor (current_floor),
        .target_floor  (target_floor),
        .moving_dir    (moving_dir),
        .door_open     (door_open),
        .illegal       (illegal)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic int lowest_stop();
        for (int i = 0; i < FLOORS; i++)
            if (hall_dir[i] != DIR_STOP || cab_req[i])
                return i;
        return -1;
    endfunction

    function automatic int highest_stop();
        for (int i = FLOORS - 1; i >= 0; i--)
            if (hall_dir[i] != DIR_STOP || cab_req[i])
                return i;
        return -1;
    endfunction

    // door opens for a hall call matching the heading, a car button, or the goal
    function automatic bit open_door();
        bit opened;
        opened = 1'b0;
        if (hall_dir[car_pos] != DIR_STOP && int'(hall_dir[car_pos]) == heading)
        begin
            opened = 1'b1;
            hall_dir[car_pos] = DIR_STOP;
        end
        if (cab_req[car_pos])
        begin
            opened = 1'b1;
            cab_req[car_pos] = 1'b0;
        end
        if (car_pos == goal_pos && heading != 0)
        begin
            opened = 1'b1;
            heading = 0;
            hall_dir[car_pos] = DIR_STOP;
        end
        return opened;
    endfunction

    // a stopped car heads for the lowest call; then the goal is the far end of
    // the calls in the heading, kept when nothing is called or it is our floor
    function automatic void retarget_car();
        int f;
        if (heading == 0)
        begin
            f = lowest_stop();
            if (f >= 0)
            begin
                if (car_pos < f)
                begin
                    heading = 1;
                    goal_pos = f;
                end
                else if (car_pos > f)
                begin
                    heading = -1;
                    goal_pos = f;
                end
            end
        end
        f = (heading == -1) ? lowest_stop() : highest_stop();
        if (f >= 0 && f != car_pos)
            goal_pos = f;
    endfunction

    function automatic car_report_t advance_car(kind_t k, floor_t f, dir_t d);
        car_report_t r;
        int fi;
        int nxt;
        r = '0;
        fi = int'(f);
        case (k)
            KIND_HALL:
                if (fi < FLOORS && (d == DIR_UP || d == DIR_DOWN))
                begin
                    if (heading == 0)
                    begin
                        heading = (fi > car_pos) ? 1 : -1;
                        goal_pos = fi;
                    end
                    if ((fi > goal_pos && heading == 1) || (fi < goal_pos && heading == -1))
                        goal_pos = fi;
                    hall_dir[fi] = d;
                end
                else
                    r.bad = 1'b1;
            KIND_CAR:
                if (fi < FLOORS)
                    cab_req[fi] = !cab_req[fi];
                else
                    r.bad = 1'b1;
            KIND_TICK:
            begin
                r.door = open_door();
                retarget_car();
                // the car never leaves the shaft: it stops at the end floors
                nxt = car_pos + heading;
                if (nxt < 0 || nxt >= FLOORS)
                    heading = 0;
                else
                    car_pos = nxt;
            end
            default:
                r.bad = 1'b1;
        endcase
        r.cur = floor_t'(car_pos);
        r.tgt = floor_t'(goal_pos);
        r.dir = dir_t'(heading);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic flag_mismatch(string field, int got, int want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns result %0d: %s is %0d, expected %0d",
                     $time, results_seen, field, got, want);
        mismatches++;
    endtask

    // results are compared before the request of the same edge is predicted;
    // a result is built in registered steps after its request, so the two never belong together
    always @(posedge clk)
    begin
        car_report_t want;
        car_report_t pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_reports.size() == 0)
                    flag_mismatch("result with no request pending", 1, 0);
                else
                begin
                    want = awaited_reports.pop_front();
                    if (current_floor !== want.cur)
                        flag_mismatch("current_floor", int'(current_floor), int'(want.cur));
                    if (target_floor !== want.tgt)
                        flag_mismatch("target_floor", int'(target_floor), int'(want.tgt));
                    if (moving_dir !== want.dir)
                        flag_mismatch("moving_dir", int'(moving_dir), int'(want.dir));
                    if (door_open !== want.door)
                        flag_mismatch("door_open", int'(door_open), int'(want.door));
                    if (illegal !== want.bad)
                        flag_mismatch("illegal", int'(illegal), int'(want.bad));
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
            begin
                pred = advance_car(req_kind, req_floor, req_dir);
                awaited_reports.push_back(row_typed ? row_want : pred);
            end
        end
    end

    // ---------------------------------------------------------------
    // request side: inputs change on the falling edge only
    // ---------------------------------------------------------------

    // hold a request on the bus until the core takes it
    task automatic send_request(kind_t k, floor_t f, dir_t d, logic typed,
                                car_report_t want);
        @(negedge clk);
        in_valid  <= 1'b1;
        req_kind  <= k;
        req_floor <= f;
        req_dir   <= d;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic hold_idle(int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // result side: stall in bursts, or free runs, never at the tail
    initial
    begin
        int  n;
        bit  hold;
        forever
        begin
            if (quiet_tail)
            begin
                hold = 1'b0;
                n = 1;
            end
            else
            begin
                hold = ($urandom_range(99) < stall_pct);
                n = $urandom_range(1, 15);
            end
            @(negedge clk);
            out_stall <= hold;
            repeat (n - 1) @(negedge clk);
        end
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("elevator_call_scheduler_core: mismatch");
        $finish;
    end

    // main sequence
    initial
    begin
        int     k_sel;
        int     in_pct;
        kind_t  k;
        floor_t f;
        dir_t   d;

        in_pct = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_request(directed[i].kind, directed[i].flr, directed[i].dir,
                         directed[i].typed, directed[i].want);

        // random traffic: mostly legal calls and ticks so the car travels far,
        // with some out-of-range floors, bad directions and unused kinds mixed in
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 100 == 0)
            begin
                in_pct = $urandom_range(2) * 25;
                stall_pct = $urandom_range(3) * 20;
            end
            quiet_tail = (i >= RANDOM_REQUESTS - QUIET_TAIL);
            if (!quiet_tail && $urandom_range(99) < in_pct)
                hold_idle($urandom_range(1, 15));

            k_sel = $urandom_range(99);
            f = floor_t'($urandom_range(63));
            d = dir_t'($urandom_range(3));
            if (k_sel < 45)
                k = KIND_TICK;
            else if (k_sel < 72)
            begin
                k = KIND_HALL;
                if ($urandom_range(9) != 0)
                begin
                    f = floor_t'($urandom_range(FLOORS - 1));
                    d = $urandom_range(1) ? DIR_UP : DIR_DOWN;
                end
            end
            else if (k_sel < 96)
            begin
                k = KIND_CAR;
                if ($urandom_range(11) != 0)
                    f = floor_t'($urandom_range(FLOORS - 1));
            end
            else
                k = KIND_UNUSED;
            send_request(k, f, d, 1'b0, NO_WANT);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        // any stray result in this window is flagged by the checker
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("elevator_call_scheduler_core: match");
        else
            $display("elevator_call_scheduler_core: mismatch");
        $finish;
    end

endmodule
